// ----- src/assert_macros.svh -----
// Assertion macros shared by the relay sequencer RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define LRPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define LRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lrps_pkg.sv -----
// Package for the latching relay pulse sequencer: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps

package lrps_pkg;

	localparam int CHANNELS = 4;
	localparam int LANES    = 4;
	localparam logic [LANES-1:0] LANE_MASK = LANES'((64'd1 << CHANNELS) - 64'd1);
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_FORCE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULSE_TICKS      = 3'd0,
		REG_CONTROL_INTERVAL = 3'd1,
		REG_BUSY_TIMEOUT     = 3'd2,
		REG_POWER_ON_DELAY   = 3'd3,
		REG_CHANNEL_MASK     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]       pulse_ticks;
		logic [15:0]      control_interval;
		logic [15:0]      busy_timeout;
		logic [15:0]      power_on_delay;
		logic [LANES-1:0] channel_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] channel;
		logic       value;
	} item_t;

	typedef struct packed {
		logic [LANES-1:0] target_bits;
		logic [LANES-1:0] present_bits;
		logic             pulsing;
		logic             pulse_finished;
		logic             active_valid;
		logic [1:0]       active_index;
		logic             active_level;
		logic [7:0]       pulse_count;
		logic [15:0]      since_control;
		logic [15:0]      busy_count;
		logic [15:0]      startup_count;
		logic             fault_flag;
	} state_t;

	typedef struct packed {
		logic [LANES-1:0] on_drive;
		logic [LANES-1:0] off_drive;
		logic [LANES-1:0] present_state;
		logic [LANES-1:0] target_state;
		logic             busy_res;
		logic             timeout_fault;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		pulse_ticks:      8'd10,
		control_interval: 16'd100,
		busy_timeout:     16'd1000,
		power_on_delay:   16'd3000,
		channel_mask:     4'hF
	};

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

// ----- src/lrps_if.sv -----
// Valid/ready channel interfaces for the relay sequencer items and results.
// Depends on lrps_pkg for field widths.
`timescale 1ns / 1ps

interface lrps_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [1:0] channel;
	logic       value;

	modport source (output valid, kind, channel, value, input ready);
	modport sink   (input valid, kind, channel, value, output ready);
endinterface

interface lrps_result_if;
	logic                      valid;
	logic                      ready;
	logic [lrps_pkg::LANES-1:0] on_drive;
	logic [lrps_pkg::LANES-1:0] off_drive;
	logic [lrps_pkg::LANES-1:0] present_state;
	logic [lrps_pkg::LANES-1:0] target_state;
	logic                      busy_res;
	logic                      timeout_fault;

	modport source (output valid, on_drive, off_drive, present_state, target_state,
		busy_res, timeout_fault, input ready);
	modport sink   (input valid, on_drive, off_drive, present_state, target_state,
		busy_res, timeout_fault, output ready);
endinterface

// ----- src/latching_relay_pulse_sequencer.sv -----
// Top level of the latching relay pulse sequencer: input register, state, result register.
// Depends on lrps_pkg, lrps_if, lrps_step and assert_macros.svh.
//
//   channel   direction  payload                                        handshake
//   item_in   sink       kind, channel, value                           valid/ready
//   result    source     on/off drive, present/target state, busy, fault valid/ready
//   cfg       write      cfg_we, cfg_index, cfg_wdata                   none
//
// One item a cycle unless the result register stalls: an accepted item sits in the input
// stage, where the step logic updates the relay state and loads the result register.
// A result is valid once its item has passed the input stage and the result register.
// Reset clears the state and restores register defaults; no clearing pass.
// A stalled result register holds the input stage, and item_in.ready drops only then.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module latching_relay_pulse_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	lrps_item_if.sink                           item_in,
	lrps_result_if.source                       result,
	input  logic                                cfg_we,
	input  logic [lrps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lrps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	lrps_pkg::cfg_t    cfg_q;
	lrps_pkg::state_t  state_q;
	lrps_pkg::state_t  state_n;
	lrps_pkg::item_t   item_s1;
	logic              valid_s1;
	lrps_pkg::result_t res_n;
	lrps_pkg::result_t res_s2;
	logic              valid_s2;
	logic              advance;

	assign advance       = valid_s1 && (!valid_s2 || result.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lrps_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrps_pkg::REG_PULSE_TICKS:      cfg_q.pulse_ticks      <= cfg_wdata[7:0];
				lrps_pkg::REG_CONTROL_INTERVAL: cfg_q.control_interval <= cfg_wdata;
				lrps_pkg::REG_BUSY_TIMEOUT:     cfg_q.busy_timeout     <= cfg_wdata;
				lrps_pkg::REG_POWER_ON_DELAY:   cfg_q.power_on_delay   <= cfg_wdata;
				lrps_pkg::REG_CHANNEL_MASK:
					cfg_q.channel_mask <= cfg_wdata[lrps_pkg::LANES-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1.kind    <= item_in.kind;
			item_s1.channel <= item_in.channel;
			item_s1.value   <= item_in.value;
		end
	end

	lrps_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.st_n (state_n),
		.res  (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_n;
	end

	assign result.valid         = valid_s2;
	assign result.on_drive      = res_s2.on_drive;
	assign result.off_drive     = res_s2.off_drive;
	assign result.present_state = res_s2.present_state;
	assign result.target_state  = res_s2.target_state;
	assign result.busy_res      = res_s2.busy_res;
	assign result.timeout_fault = res_s2.timeout_fault;

	`LRPS_ASSERT(a_one_coil, !valid_s2 || $onehot0({res_s2.on_drive, res_s2.off_drive}), "both coils or several channels driven")
	`LRPS_ASSERT_NEXT(a_fault_sticky, state_q.fault_flag, state_q.fault_flag, "timeout fault cleared without reset")
	`LRPS_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1), "input stage lost an item while stalled")
	`LRPS_ASSERT(a_drive_valid, !state_q.pulsing || (state_q.active_valid && state_q.pulse_count != 8'd0), "pulse state inconsistent")

endmodule

// ----- src/lrps_step.sv -----
// Next-state and result logic for one item of the relay sequencer.
// Depends on lrps_pkg.
`timescale 1ns / 1ps

module lrps_step (
	input  lrps_pkg::cfg_t    cfg,
	input  lrps_pkg::state_t  st,
	input  lrps_pkg::item_t   item,
	output lrps_pkg::state_t  st_n,
	output lrps_pkg::result_t res
);

	logic [lrps_pkg::LANES-1:0] use_mask;
	logic [lrps_pkg::LANES-1:0] diff;
	logic [lrps_pkg::LANES-1:0] sel_bit;
	logic [lrps_pkg::LANES-1:0] drive;
	logic                       found;
	logic                       busy;

	assign use_mask = cfg.channel_mask & lrps_pkg::LANE_MASK;

	always_comb begin
		st_n    = st;
		diff    = '0;
		sel_bit = '0;
		found   = 1'b0;
		case (item.kind) inside
			lrps_pkg::KIND_TICK: begin
				st_n.since_control = lrps_pkg::sat_inc(st.since_control);
				st_n.busy_count    = lrps_pkg::sat_inc(st.busy_count);
				st_n.startup_count = lrps_pkg::sat_inc(st.startup_count);
				if (st.pulsing) begin
					if (st.pulse_count != 8'd0)
						st_n.pulse_count = st.pulse_count - 8'd1;
					if (st_n.pulse_count == 8'd0) begin
						st_n.pulsing        = 1'b0;
						st_n.pulse_finished = 1'b1;
					end
				end
				if (st_n.startup_count >= cfg.power_on_delay) begin
					st_n.startup_count = lrps_pkg::CNT_MAX;
					diff = (st.target_bits ^ st.present_bits) & use_mask;
					if (st_n.since_control < cfg.control_interval && !st_n.pulsing
							&& diff != '0) begin
						st_n.busy_count = 16'd0;
					end else if (st_n.pulsing) begin
						if (st_n.busy_count > cfg.busy_timeout)
							st_n.fault_flag = 1'b1;
					end else begin
						st_n.busy_count = 16'd0;
						if (st_n.pulse_finished) begin
							if (st.active_valid) begin
								sel_bit = lrps_pkg::LANES'(1) << st.active_index;
								if (st.active_level)
									st_n.present_bits = st.present_bits | sel_bit;
								else
									st_n.present_bits = st.present_bits & ~sel_bit;
								st_n.present_bits = st_n.present_bits & cfg.channel_mask;
								st_n.active_valid = 1'b0;
							end
							st_n.pulse_finished = 1'b0;
						end
						diff = (st_n.target_bits ^ st_n.present_bits) & use_mask;
						for (int i = 0; i < lrps_pkg::LANES; i++) begin
							if (!found && diff[i]) begin
								found              = 1'b1;
								st_n.active_index  = 2'(i);
								st_n.active_level  = st_n.target_bits[i];
								st_n.active_valid  = 1'b1;
								st_n.pulsing       = 1'b1;
								st_n.pulse_count   = (cfg.pulse_ticks != 8'd0) ?
									cfg.pulse_ticks : 8'd1;
								st_n.since_control = 16'd0;
							end
						end
					end
				end
			end
			lrps_pkg::KIND_SET, lrps_pkg::KIND_FORCE: begin
				if (int'(item.channel) < lrps_pkg::CHANNELS) begin
					sel_bit = lrps_pkg::LANES'(1) << item.channel;
					if (item.value)
						st_n.target_bits = st.target_bits | sel_bit;
					else
						st_n.target_bits = st.target_bits & ~sel_bit;
					st_n.target_bits = st_n.target_bits & cfg.channel_mask;
					if (item.kind == lrps_pkg::KIND_FORCE) begin
						if (item.value)
							st_n.present_bits = st.present_bits & ~sel_bit;
						else
							st_n.present_bits = st.present_bits | sel_bit;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		drive = '0;
		if (st_n.pulsing && st_n.active_valid)
			drive = lrps_pkg::LANES'(1) << st_n.active_index;
		busy = st_n.pulsing ||
			(st_n.startup_count >= cfg.power_on_delay &&
			 st_n.since_control < cfg.control_interval &&
			 ((st_n.target_bits ^ st_n.present_bits) & use_mask) != '0);
		res.on_drive      = st_n.active_level ? drive : '0;
		res.off_drive     = st_n.active_level ? '0 : drive;
		res.present_state = st_n.present_bits;
		res.target_state  = st_n.target_bits;
		res.busy_res      = busy;
		res.timeout_fault = st_n.fault_flag;
	end

endmodule

// ----- sim/tb_latching_relay_pulse_sequencer.sv -----
// Self-checking bench for the latching relay pulse sequencer: a table of directed items,
// then random phases under several register settings and idle patterns.
// Depends on lrps_pkg, lrps_if and the sequencer RTL; results are checked by a local predictor.
`timescale 1ns / 1ps

module tb_latching_relay_pulse_sequencer;
	import lrps_pkg::*;

	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES = 7;
	localparam int STALL_LIMIT = 6000;
	localparam int HOLD_CYCLES = 250;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		bit          is_reg;
		reg_idx_t    idx;
		logic [15:0] data;
		logic [1:0]  kind;
		logic [1:0]  ch;
		logic        val;
		bit          typed;
		result_t     want;
	} step_t;

	localparam result_t NO_RES = '0;
	localparam int DIRECTED_ROWS = 38;
	localparam step_t DIRECTED [DIRECTED_ROWS] = '{
		// register defaults: power-on delay holds off every pulse
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_SET, 2'd0, 1'b1, 1'b1, '{4'h0, 4'h0, 4'h0, 4'h1, 1'b0, 1'b0}},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b1, '{4'h0, 4'h0, 4'h0, 4'h1, 1'b0, 1'b0}},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_FORCE, 2'd1, 1'b1, 1'b1, '{4'h0, 4'h0, 4'h0, 4'h3, 1'b0, 1'b0}},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_FORCE, 2'd2, 1'b0, 1'b1, '{4'h0, 4'h0, 4'h4, 4'h3, 1'b0, 1'b0}},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_RESERVED, 2'd3, 1'b1, 1'b1, '{4'h0, 4'h0, 4'h4, 4'h3, 1'b0, 1'b0}},
		'{1'b1, REG_POWER_ON_DELAY, 16'd3, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b1, '{4'h0, 4'h0, 4'h4, 4'h3, 1'b0, 1'b0}},
		// delay done, rate limit still holds the pending change
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b1, '{4'h0, 4'h0, 4'h4, 4'h3, 1'b1, 1'b0}},
		'{1'b1, REG_CONTROL_INTERVAL, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		// zero pulse length runs as one tick on channel 0
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b1, '{4'h1, 4'h0, 4'h4, 4'h3, 1'b1, 1'b0}},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_SET, 2'd3, 1'b1, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_CHANNEL_MASK, 16'h9, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_SET, 2'd1, 1'b1, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_FORCE, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_PULSE_TICKS, 16'd255, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_CONTROL_INTERVAL, 16'd65535, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_BUSY_TIMEOUT, 16'd65535, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_POWER_ON_DELAY, 16'd65535, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_CHANNEL_MASK, 16'h0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_SET, 2'd2, 1'b1, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_FORCE, 2'd3, 1'b1, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_CHANNEL_MASK, 16'hF, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_PULSE_TICKS, 16'd2, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_CONTROL_INTERVAL, 16'd1, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_POWER_ON_DELAY, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_SET, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_SET, 2'd3, 1'b1, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_PULSE_TICKS, 16'd0, KIND_TICK, 2'd0, 1'b0, 1'b0, NO_RES}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lrps_item_if   item_ch ();
	lrps_result_if res_ch ();

	latching_relay_pulse_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// register copies
	logic [7:0]  len_cfg;
	logic [15:0] gap_cfg;
	logic [15:0] tmo_cfg;
	logic [15:0] boot_cfg;
	logic [3:0]  mask_cfg;

	// relay state copies
	logic [3:0]  tgt_mask;
	logic [3:0]  pres_mask;
	logic        pulse_on;
	logic        pulse_done;
	logic        drive_armed;
	logic [1:0]  drive_ch;
	logic        drive_on;
	logic [7:0]  pulse_left;
	logic [15:0] since_start;
	logic [15:0] busy_ticks;
	logic [15:0] boot_ticks;
	logic        fault_seen;

	result_t want_results [$];
	int idle_pct = 0;
	int stall_pct = 0;
	int tick_pct = 60;
	int hold_asked = 0;
	int mismatches = 0;
	int checked = 0;
	int items_sent = 0;
	int pulse_starts = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] count_up(input logic [15:0] v);
		return v + {15'd0, ~&v};
	endfunction

	function automatic logic [3:0] pending_diff();
		return (tgt_mask ^ pres_mask) & mask_cfg;
	endfunction

	function automatic void clear_relay_model();
		len_cfg = 8'd10;
		gap_cfg = 16'd100;
		tmo_cfg = 16'd1000;
		boot_cfg = 16'd3000;
		mask_cfg = 4'hF;
		tgt_mask = '0;
		pres_mask = '0;
		pulse_on = 1'b0;
		pulse_done = 1'b0;
		drive_armed = 1'b0;
		drive_ch = '0;
		drive_on = 1'b0;
		pulse_left = '0;
		since_start = '0;
		busy_ticks = '0;
		boot_ticks = '0;
		fault_seen = 1'b0;
	endfunction

	function automatic void advance_tick();
		logic [3:0] diff;
		bit found;
		found = 1'b0;
		since_start = count_up(since_start);
		busy_ticks = count_up(busy_ticks);
		boot_ticks = count_up(boot_ticks);
		if (pulse_on) begin
			if (pulse_left != 8'd0)
				pulse_left = pulse_left - 8'd1;
			if (pulse_left == 8'd0) begin
				pulse_on = 1'b0;
				pulse_done = 1'b1;
			end
		end
		if (boot_ticks < boot_cfg)
			return;
		boot_ticks = 16'hFFFF;
		// rate limit returns before the commit of a finished pulse
		if (since_start < gap_cfg && !pulse_on && pending_diff() != 4'd0) begin
			busy_ticks = '0;
			return;
		end
		if (!pulse_on)
			busy_ticks = '0;
		else if (busy_ticks > tmo_cfg)
			fault_seen = 1'b1;
		if (pulse_on)
			return;
		if (pulse_done) begin
			if (drive_armed) begin
				pres_mask[drive_ch] = drive_on;
				pres_mask &= mask_cfg;
				drive_armed = 1'b0;
			end
			pulse_done = 1'b0;
		end
		diff = pending_diff();
		for (int i = 0; i < 4; i++) begin
			if (diff[i] && !found) begin
				found = 1'b1;
				drive_ch = 2'(i);
				drive_on = tgt_mask[i];
				drive_armed = 1'b1;
				pulse_on = 1'b1;
				pulse_left = (len_cfg != 8'd0) ? len_cfg : 8'd1;
				since_start = '0;
				pulse_starts++;
			end
		end
	endfunction

	function automatic result_t next_relay_result(input logic [1:0] kind, input logic [1:0] ch,
			input logic val);
		result_t r;
		logic [3:0] drive;
		drive = '0;
		if (kind == KIND_TICK) begin
			advance_tick();
		end else if (kind == KIND_SET || kind == KIND_FORCE) begin
			tgt_mask[ch] = val;
			tgt_mask &= mask_cfg;
			if (kind == KIND_FORCE)
				pres_mask[ch] = ~val;
		end
		if (pulse_on && drive_armed)
			drive[drive_ch] = 1'b1;
		r.on_drive = drive_on ? drive : 4'd0;
		r.off_drive = drive_on ? 4'd0 : drive;
		r.present_state = pres_mask;
		r.target_state = tgt_mask;
		r.busy_res = pulse_on || (boot_ticks >= boot_cfg && since_start < gap_cfg
			&& pending_diff() != 4'd0);
		r.timeout_fault = fault_seen;
		return r;
	endfunction

	task automatic offer_item(input logic [1:0] kind, input logic [1:0] ch, input logic val,
			input bit typed, input result_t want);
		result_t guess;
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.channel <= ch;
		item_ch.value <= val;
		do begin
			@(posedge clk);
		end while (!item_ch.ready);
		guess = next_relay_result(kind, ch, val);
		want_results.push_back(typed ? want : guess);
		items_sent++;
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (want_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PULSE_TICKS:      len_cfg = data[7:0];
			REG_CONTROL_INTERVAL: gap_cfg = data;
			REG_BUSY_TIMEOUT:     tmo_cfg = data;
			REG_POWER_ON_DELAY:   boot_cfg = data;
			REG_CHANNEL_MASK:     mask_cfg = data[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] len, input logic [15:0] gap,
			input logic [15:0] tmo, input logic [15:0] boot, input logic [3:0] mask);
		drain_results();
		write_reg(REG_PULSE_TICKS, {8'd0, len});
		write_reg(REG_CONTROL_INTERVAL, gap);
		write_reg(REG_BUSY_TIMEOUT, tmo);
		write_reg(REG_POWER_ON_DELAY, boot);
		write_reg(REG_CHANNEL_MASK, {12'd0, mask});
	endtask

	task automatic match_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic check_result();
		result_t want;
		if (want_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result arrived with nothing expected");
			return;
		end
		want = want_results.pop_front();
		match_field("on_drive", want.on_drive, res_ch.on_drive);
		match_field("off_drive", want.off_drive, res_ch.off_drive);
		match_field("present_state", want.present_state, res_ch.present_state);
		match_field("target_state", want.target_state, res_ch.target_state);
		match_field("busy_res", {3'd0, want.busy_res}, {3'd0, res_ch.busy_res});
		match_field("timeout_fault", {3'd0, want.timeout_fault}, {3'd0, res_ch.timeout_fault});
		checked++;
	endtask

	// result side: random stalls, plus a long hold when asked
	initial begin
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				check_result();
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: %0d cycles with no item moving", quiet);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int pick;
		logic [1:0] kind;
		item_ch.valid <= 1'b0;
		item_ch.kind <= KIND_TICK;
		item_ch.channel <= 2'd0;
		item_ch.value <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PULSE_TICKS;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		clear_relay_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_reg) begin
				drain_results();
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				offer_item(DIRECTED[i].kind, DIRECTED[i].ch, DIRECTED[i].val,
					DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			tick_pct = 60;
			case (ph)
				0: begin
					load_settings(8'd1, 16'd0, 16'd65535, 16'd0, 4'hF);
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					load_settings(8'd3, 16'd4, 16'd1000, 16'd0, 4'h5);
					idle_pct = 86;
					stall_pct = 0;
				end
				2: begin
					load_settings(8'd0, 16'd2, 16'd1000, 16'd0, 4'hF);
					idle_pct = 0;
					stall_pct = 86;
				end
				3: begin
					// long interval: pending changes and finished pulses wait
					load_settings(8'd255, 16'd65535, 16'd65535, 16'd65535, 4'hF);
					idle_pct = 34;
					stall_pct = 34;
					tick_pct = 90;
				end
				4: begin
					load_settings(8'd2, 16'd1, 16'd1000, 16'd0, 4'hA);
					idle_pct = 0;
					stall_pct = 0;
					hold_asked++;
				end
				5: begin
					load_settings(8'($urandom_range(12)), 16'($urandom_range(10)),
						16'($urandom_range(65535, 200)), 16'($urandom_range(65535)),
						4'($urandom_range(15)));
					idle_pct = 34;
					stall_pct = 34;
				end
				default: begin
					// short timeout: sticky fault from here on
					load_settings(8'd5, 16'd0, 16'd1, 16'd0, 4'hF);
					idle_pct = 0;
					stall_pct = 86;
				end
			endcase
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < tick_pct)
					kind = KIND_TICK;
				else if (pick < tick_pct + (100 - tick_pct) / 2)
					kind = KIND_SET;
				else if (pick < 96)
					kind = KIND_FORCE;
				else
					kind = KIND_RESERVED;
				offer_item(kind, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, NO_RES);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		$display("covered %0d items over the directed table and %0d register settings",
			items_sent, PHASES);
		$display("%0d results checked, %0d relay pulses started, fault raised: %0d",
			checked, pulse_starts, fault_seen);
		if (mismatches == 0 && want_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/lrps_pkg.sv
src/lrps_if.sv
src/lrps_step.sv
src/latching_relay_pulse_sequencer.sv
sim/tb_latching_relay_pulse_sequencer.sv
